// ----- sv/pwe_pkg.sv -----
// shared types, constants and table functions for the periodic waveform evaluator
package pwe_pkg;

    localparam int PW = 31;   // period width
    localparam int XW = 34;   // cordic x/y width, Q30
    localparam int ZW = 36;   // cordic angle width, Q32 radians
    localparam int TW = 33;   // triangle value width, Q30
    localparam int OW = 34;   // early multiplier operand width

    typedef enum logic [2:0] {
        MODE_CONST    = 3'd0,
        MODE_LINEAR   = 3'd1,
        MODE_SINE     = 3'd2,
        MODE_COSINE   = 3'd3,
        MODE_PULSE    = 3'd4,
        MODE_TRIANGLE = 3'd5,
        MODE_SAW      = 3'd6,
        MODE_INVALID  = 3'd7
    } pwe_mode_t;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_AMP    = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;
    localparam logic [2:0] REG_PHASE  = 3'd4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic signed [63:0] PI_Q29 = 64'sd1686629713;
    localparam logic signed [63:0] INV_TWO_PI_Q32 = 64'sd683565276;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic               t_neg;
        logic signed [32:0] tph;
    } pwe_dside_t;

    typedef struct packed {
        logic [1:0]           quad;
        logic signed [TW-1:0] tri_val;
        logic signed [OW-1:0] opnd;
    } pwe_cside_t;

    // series term divided by the odd number 2k+1
    function automatic logic [63:0] div_odd(input logic [63:0] x, input int unsigned k);
        logic [63:0] r;
        case (k)
            0:  r = x / 1;
            1:  r = x / 3;
            2:  r = x / 5;
            3:  r = x / 7;
            4:  r = x / 9;
            5:  r = x / 11;
            6:  r = x / 13;
            7:  r = x / 15;
            8:  r = x / 17;
            9:  r = x / 19;
            10: r = x / 21;
            11: r = x / 23;
            12: r = x / 25;
            13: r = x / 27;
            14: r = x / 29;
            15: r = x / 31;
            16: r = x / 33;
            17: r = x / 35;
            18: r = x / 37;
            19: r = x / 39;
            20: r = x / 41;
            21: r = x / 43;
            22: r = x / 45;
            23: r = x / 47;
            24: r = x / 49;
            25: r = x / 51;
            26: r = x / 53;
            27: r = x / 55;
            28: r = x / 57;
            29: r = x / 59;
            30: r = x / 61;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // atan(2^-i) in Q32 radians, series truncated at Q62
    function automatic logic [63:0] atan_q32(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned sh;
        acc = 64'd0;
        if (i == 0) begin
            acc = PI_Q60;
        end else begin
            for (int unsigned k = 0; k < 31; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 62) begin
                    term = div_odd((64'd1 << 62) >> sh, k);
                    if (k % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return (acc + (64'd1 << 29)) >> 30;
    endfunction

endpackage

// ----- sv/pwe_divpipe.sv -----
// pipelined restoring divider, one quotient bit per stage
module pwe_divpipe #(
    parameter int STEPS = 33,
    parameter int SW = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [STEPS-1:0]       in_num,
    input  logic [pwe_pkg::PW-1:0] in_rem,
    input  logic [SW-1:0]          in_side,
    input  logic [pwe_pkg::PW-1:0] divisor,
    output logic                   out_valid,
    output logic [pwe_pkg::PW-1:0] out_rem,
    output logic [STEPS-1:0]       out_quo,
    output logic [SW-1:0]          out_side
);
    import pwe_pkg::*;

    logic             vld_reg  [STEPS];
    logic [PW-1:0]    rem_reg  [STEPS];
    logic [STEPS-1:0] nq_reg   [STEPS];
    logic [SW-1:0]    side_reg [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic             vld_in;
            logic [PW-1:0]    rem_in;
            logic [STEPS-1:0] nq_in;
            logic [SW-1:0]    side_in;
            logic [PW:0]      shl;
            logic [PW:0]      diff;
            logic             ge;

            if (i == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = in_rem;
                assign nq_in   = in_num;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign nq_in   = nq_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            // dividend bits leave at the top, quotient bits enter at the bottom
            assign shl  = {rem_in, nq_in[STEPS-1]};
            assign diff = shl - {1'b0, divisor};
            assign ge   = (shl >= {1'b0, divisor});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= ge ? diff[PW-1:0] : shl[PW-1:0];
                nq_reg[i]   <= {nq_in[STEPS-2:0], ge};
                side_reg[i] <= side_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[STEPS-1];
    assign out_rem   = rem_reg[STEPS-1];
    assign out_quo   = nq_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- sv/pwe_cordic.sv -----
// pipelined rotation-mode cordic, one micro-rotation per stage
module pwe_cordic #(
    parameter int STAGES = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [pwe_pkg::ZW-1:0] in_z,
    input  pwe_pkg::pwe_cside_t           in_side,
    output logic                          out_valid,
    output logic signed [pwe_pkg::XW-1:0] out_x,
    output logic signed [pwe_pkg::XW-1:0] out_y,
    output pwe_pkg::pwe_cside_t           out_side
);
    import pwe_pkg::*;

    logic                 vld_reg  [STAGES];
    logic signed [XW-1:0] x_reg    [STAGES];
    logic signed [XW-1:0] y_reg    [STAGES];
    logic signed [ZW-1:0] z_reg    [STAGES];
    pwe_cside_t           side_reg [STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_q32(i));
            logic                 vld_in;
            logic signed [XW-1:0] x_in;
            logic signed [XW-1:0] y_in;
            logic signed [ZW-1:0] z_in;
            pwe_cside_t           side_in;

            if (i == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign x_in    = CORDIC_GAIN_Q30;
                assign y_in    = '0;
                assign z_in    = in_z;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[i-1];
                assign x_in    = x_reg[i-1];
                assign y_in    = y_reg[i-1];
                assign z_in    = z_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (z_in >= 0)
                begin
                    x_reg[i] <= x_in - (y_in >>> i);
                    y_reg[i] <= y_in + (x_in >>> i);
                    z_reg[i] <= z_in - ATAN_I;
                end
                else
                begin
                    x_reg[i] <= x_in + (y_in >>> i);
                    y_reg[i] <= y_in - (x_in >>> i);
                    z_reg[i] <= z_in + ATAN_I;
                end
                side_reg[i] <= side_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_y     = y_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- sv/periodic_waveform_evaluator_unit.sv -----
// top level: register port, input stage, dividers, cordic and output stages
//
//  port group     direction  transaction marker          payload
//  command        in         start && !busy              time_value
//  result         out        done (one cycle)            wave_value, saturated
//  config (apb)   in/out     psel&penable&pwrite&pready  paddr, pwdata / prdata
//
//  one transaction enters every cycle; busy is never raised
//  results pass through the two bit-per-stage dividers
//  (33 remainder stages, 32 fraction stages) and the cordic
//  reset clears the valid bits and loads the register defaults
//  results cannot be stalled, so the pipeline never holds
module periodic_waveform_evaluator_unit #(
    parameter int FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] time_value,
    output logic               done,
    output logic signed [31:0] wave_value,
    output logic               saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pwe_pkg::*;

    localparam logic signed [TW-1:0] TRI_POS = 33'sd1073741824;
    localparam logic signed [TW-1:0] TRI_NEG = -33'sd1073741824;
    localparam logic signed [TW-1:0] TURN_HALF = 33'sd2147483648;
    localparam logic signed [68:0] SUM_MAX = 69'sd2147483647;
    localparam logic signed [68:0] SUM_MIN = -69'sd2147483648;
    localparam logic [66:0] HALF_TRIG = 67'd1 << 29;
    localparam logic [66:0] HALF_LIN = 67'd1 << (FRAC_BITS - 1);
    localparam logic [66:0] HALF_SAW = 67'd1 << FRAC_BITS;

    // configuration registers
    pwe_mode_t          mode_reg;
    logic signed [31:0] offset_reg;
    logic signed [31:0] amp_reg;
    logic [PW-1:0]      period_reg;
    logic signed [31:0] phase_reg;
    logic [31:0]        fh_reg;
    logic signed [63:0] fh_prod;
    logic [PW-1:0]      pdiv;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite;
    assign pdiv   = (period_reg == '0) ? PW'(1) : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CONST;
            offset_reg <= '0;
            amp_reg    <= 32'sd65536;
            period_reg <= PW'(65536);
            phase_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_MODE:   mode_reg   <= pwe_mode_t'(pwdata[2:0]);
                REG_OFFSET: offset_reg <= pwdata;
                REG_AMP:    amp_reg    <= pwdata;
                REG_PERIOD: period_reg <= pwdata[PW-1:0];
                REG_PHASE:  phase_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MODE:   prdata = {29'd0, mode_reg};
            REG_OFFSET: prdata = offset_reg;
            REG_AMP:    prdata = amp_reg;
            REG_PERIOD: prdata = {1'b0, period_reg};
            REG_PHASE:  prdata = phase_reg;
            default:    prdata = '0;
        endcase
    end

    // phase in turns, Q32
    assign fh_prod = 64'(phase_reg) * INV_TWO_PI_Q32;

    always_ff @(posedge clk)
    begin
        fh_reg <= fh_prod[FRAC_BITS+31:FRAC_BITS];
    end

    // input stage and magnitudes
    logic               s0_vld_reg;
    logic signed [31:0] t_reg;
    logic signed [32:0] tph_reg;
    logic               s1_vld_reg;
    logic [32:0]        magt_reg;
    logic [32:0]        magtph_reg;
    pwe_dside_t         s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= time_value;
        tph_reg <= 33'(time_value) + 33'(phase_reg);
        magt_reg   <= t_reg[31] ? (33'd0 - 33'(t_reg)) : 33'(t_reg);
        magtph_reg <= tph_reg[32] ? (33'd0 - tph_reg) : tph_reg;
        s1_side_reg.t_neg <= t_reg[31];
        s1_side_reg.tph   <= tph_reg;
    end

    // remainder lanes: time mod period and (time + phase) rem period
    logic          da_vld;
    logic [PW-1:0] ra;
    logic [32:0]   da_quo;
    logic [$bits(pwe_dside_t)-1:0] da_side_vec;
    pwe_dside_t    da_side;
    logic          db_vld;
    logic [PW-1:0] rb;
    logic [32:0]   db_quo;
    logic          db_neg;

    pwe_divpipe #(
        .STEPS (33),
        .SW    ($bits(pwe_dside_t))
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .in_num    (magt_reg),
        .in_rem    ('0),
        .in_side   (s1_side_reg),
        .divisor   (pdiv),
        .out_valid (da_vld),
        .out_rem   (ra),
        .out_quo   (da_quo),
        .out_side  (da_side_vec)
    );

    pwe_divpipe #(
        .STEPS (33),
        .SW    (1)
    ) u_div_tph (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_vld_reg),
        .in_num    (magtph_reg),
        .in_rem    ('0),
        .in_side   (s1_side_reg.tph[32]),
        .divisor   (pdiv),
        .out_valid (db_vld),
        .out_rem   (rb),
        .out_quo   (db_quo),
        .out_side  (db_neg)
    );

    assign da_side = pwe_dside_t'(da_side_vec);

    // fix-up: floored remainder and the sawtooth / linear operand
    logic                 fx_vld_reg;
    logic [PW-1:0]        rfloor_reg;
    logic signed [OW-1:0] fx_opnd_reg;
    logic [PW-1:0]        rfloor_next;
    logic signed [31:0]   rtr;
    logic signed [OW-1:0] saw;
    logic signed [OW-1:0] pdiv_s;

    assign rfloor_next = (da_side.t_neg && ra != '0) ? (pdiv - ra) : ra;
    assign rtr    = db_neg ? -$signed({1'b0, rb}) : $signed({1'b0, rb});
    assign pdiv_s = $signed({3'b000, pdiv});
    assign saw    = (OW'(rtr) <<< 1) - pdiv_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_vld_reg <= 1'b0;
        end
        else
        begin
            fx_vld_reg <= da_vld && db_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rfloor_reg  <= rfloor_next;
        fx_opnd_reg <= (mode_reg == MODE_LINEAR) ? OW'(da_side.tph) : saw;
    end

    // fraction of a period, Q32
    logic                 fr_vld;
    logic [PW-1:0]        fr_rem;
    logic [31:0]          ft;
    logic [OW-1:0]        fr_opnd;

    pwe_divpipe #(
        .STEPS (32),
        .SW    (OW)
    ) u_div_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fx_vld_reg),
        .in_num    ('0),
        .in_rem    (rfloor_reg),
        .in_side   (fx_opnd_reg),
        .divisor   (pdiv),
        .out_valid (fr_vld),
        .out_rem   (fr_rem),
        .out_quo   (ft),
        .out_side  (fr_opnd)
    );

    // turn phase, quadrant reduction and triangle
    logic                 a1_vld_reg;
    logic [1:0]           quad_reg;
    logic signed [30:0]   v_reg;
    logic signed [TW-1:0] tri_reg;
    logic signed [OW-1:0] a1_opnd_reg;
    logic [31:0]          u;
    logic [31:0]          qsum;
    logic [31:0]          w;
    logic signed [TW-1:0] g;
    logic signed [TW-1:0] tri_next;

    assign u    = ft + fh_reg;
    assign qsum = u + 32'h2000_0000;
    assign w    = u - {qsum[31:30], 30'd0};
    assign g    = TW'($signed(u));

    always_comb
    begin
        if (g > TRI_POS)
        begin
            tri_next = TURN_HALF - g;
        end
        else if (g < TRI_NEG)
        begin
            tri_next = -TURN_HALF - g;
        end
        else
        begin
            tri_next = g;
        end
    end

    // residual angle in Q32 radians
    logic                 a2_vld_reg;
    logic signed [ZW-1:0] z0_reg;
    pwe_cside_t           a2_side_reg;
    logic signed [63:0]   zprod;

    assign zprod = 64'(v_reg) * PI_Q29;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
        end
        else
        begin
            a1_vld_reg <= fr_vld;
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg    <= qsum[31:30];
        v_reg       <= $signed(w[30:0]);
        tri_reg     <= tri_next;
        a1_opnd_reg <= $signed(fr_opnd);
        z0_reg      <= ZW'(zprod >>> 28);
        a2_side_reg.quad    <= quad_reg;
        a2_side_reg.tri_val <= tri_reg;
        a2_side_reg.opnd    <= a1_opnd_reg;
    end

    logic                 co_vld;
    logic signed [XW-1:0] co_x;
    logic signed [XW-1:0] co_y;
    pwe_cside_t           co_side;

    pwe_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a2_vld_reg),
        .in_z      (z0_reg),
        .in_side   (a2_side_reg),
        .out_valid (co_vld),
        .out_x     (co_x),
        .out_y     (co_y),
        .out_side  (co_side)
    );

    // operand select
    logic signed [XW-1:0] sin_v;
    logic signed [XW-1:0] cos_v;
    logic signed [OW-1:0] b_next;
    logic                 o1_vld_reg;
    logic signed [OW-1:0] b_reg;
    logic                 o1_sneg_reg;

    always_comb
    begin
        case (co_side.quad)
            2'd0:
            begin
                sin_v = co_y;
                cos_v = co_x;
            end
            2'd1:
            begin
                sin_v = co_x;
                cos_v = -co_y;
            end
            2'd2:
            begin
                sin_v = -co_y;
                cos_v = -co_x;
            end
            default:
            begin
                sin_v = -co_x;
                cos_v = co_y;
            end
        endcase

        case (mode_reg)
            MODE_SINE:     b_next = sin_v;
            MODE_COSINE:   b_next = cos_v;
            MODE_TRIANGLE: b_next = OW'(co_side.tri_val);
            default:       b_next = co_side.opnd;
        endcase
    end

    // magnitude product
    logic               o2_vld_reg;
    logic [65:0]        prod_reg;
    logic               neg_reg;
    logic               o2_sneg_reg;
    logic [31:0]        maga;
    logic [OW-1:0]      magb;

    assign maga = amp_reg[31] ? (32'd0 - amp_reg) : amp_reg;
    assign magb = b_reg[OW-1] ? (OW'(0) - b_reg) : b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_vld_reg <= 1'b0;
            o2_vld_reg <= 1'b0;
        end
        else
        begin
            o1_vld_reg <= co_vld;
            o2_vld_reg <= o1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        o1_sneg_reg <= sin_v[XW-1];
        prod_reg    <= 66'(maga) * 66'(magb);
        neg_reg     <= amp_reg[31] ^ b_reg[OW-1];
        o2_sneg_reg <= o1_sneg_reg;
    end

    // rounding, offset and saturation
    logic [66:0]        r_trig;
    logic [66:0]        r_lin;
    logic [66:0]        r_saw;
    logic [66:0]        rmag;
    logic signed [67:0] term;
    logic signed [67:0] amag;
    logic signed [68:0] sum;
    logic               sat_hi;
    logic               sat_lo;
    logic signed [31:0] wave_next;
    logic               sat_next;
    logic               done_reg;
    logic signed [31:0] wave_value_reg;
    logic               saturated_reg;

    assign r_trig = ({1'b0, prod_reg} + HALF_TRIG) >> 30;
    assign r_lin  = ({1'b0, prod_reg} + HALF_LIN) >> FRAC_BITS;
    assign r_saw  = ({1'b0, prod_reg} + HALF_SAW) >> (FRAC_BITS + 1);
    assign amag   = $signed({36'd0, maga});

    always_comb
    begin
        case (mode_reg)
            MODE_LINEAR: rmag = r_lin;
            MODE_SAW:    rmag = r_saw;
            default:     rmag = r_trig;
        endcase

        case (mode_reg)
            MODE_CONST: term = 68'(amp_reg);
            MODE_PULSE: term = o2_sneg_reg ? -amag : amag;
            default:    term = neg_reg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        endcase

        sum    = 69'(offset_reg) + 69'(term);
        sat_hi = (sum > SUM_MAX);
        sat_lo = (sum < SUM_MIN);

        if (mode_reg == MODE_INVALID)
        begin
            wave_next = '0;
            sat_next  = 1'b0;
        end
        else if (sat_hi)
        begin
            wave_next = 32'sh7FFF_FFFF;
            sat_next  = 1'b1;
        end
        else if (sat_lo)
        begin
            wave_next = 32'sh8000_0000;
            sat_next  = 1'b1;
        end
        else
        begin
            wave_next = sum[31:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= o2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o2_vld_reg)
        begin
            wave_value_reg <= wave_next;
            saturated_reg  <= sat_next;
        end
    end

    assign done       = done_reg;
    assign wave_value = wave_value_reg;
    assign saturated  = saturated_reg;

    a_floor_rem: assert property (@(posedge clk) disable iff (!rst_n)
        fx_vld_reg |-> (rfloor_reg < pdiv))
        else $error("floored remainder not below period");

    a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
        a1_vld_reg |-> (tri_reg <= TRI_POS && tri_reg >= TRI_NEG))
        else $error("triangle value out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == MODE_INVALID) |-> (wave_value == 32'sd0 && !saturated))
        else $error("invalid mode gave a nonzero result");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (wave_value == 32'sh7FFF_FFFF || wave_value == 32'sh8000_0000))
        else $error("saturated result not at a range limit");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the periodic waveform evaluator unit
`timescale 1ns / 100ps

module tb_top;
    import pwe_pkg::*;

    localparam int STAGES    = 18;
    localparam int FRACB     = 16;
    localparam int IDLE_LIM  = 5000;
    localparam int DRAIN_CYC = 120;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } wave_sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] time_value = '0;
    logic               done;
    logic signed [31:0] wave_value;
    logic               saturated;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // register shadow
    pwe_mode_t   cur_mode = MODE_CONST;
    logic [31:0] cur_offset = 32'd0;
    logic [31:0] cur_amp = 32'd65536;
    logic [30:0] cur_period = 31'd65536;
    logic [31:0] cur_phase = 32'd0;

    longint      atan_q32_tab [STAGES];
    wave_sample_t pending_samples [$];
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_mismatch = 0;
    int          n_cfg = 0;
    int          idle_cnt = 0;

    periodic_waveform_evaluator_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .time_value(time_value), .done(done), .wave_value(wave_value),
        .saturated(saturated), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // arctangent of 2^-i as Q32 radians from the odd power series
    function automatic longint atan_entry(input int i);
        longint unsigned acc;
        longint unsigned term;
        int sh;
        int k;
        acc = 0;
        if (i == 0) begin
            acc = PI_Q60;
        end else begin
            k = 0;
            sh = i;
            while (sh <= 62) begin
                term = ((64'd1 << 62) >> sh) / longint'(2 * k + 1);
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
                k++;
                sh = i * (2 * k + 1);
            end
        end
        return longint'((acc + (64'd1 << 29)) >> 30);
    endfunction

    // magnitude rounding with ties away from zero
    function automatic longint scale_round(input longint a, input longint b, input int sh);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned prod;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        prod = (ma * mb + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic void sin_cos_q30(input logic [31:0] turn, output longint s,
                                        output longint c);
        logic [31:0] quad;
        logic [31:0] resid;
        longint x, y, z, dx, dy;
        quad = ((turn + 32'h2000_0000) >> 30) & 32'd3;
        resid = turn - (quad << 30);
        z = (longint'(signed'(resid)) * longint'(PI_Q29)) >>> 28;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q32_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_q32_tab[i];
            end
        end
        case (quad)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic wave_sample_t eval_wave(input logic [31:0] tv);
        wave_sample_t res;
        longint t, per, off, amp, ph, rem, term, sum, s, c, g, tri_q30;
        logic [31:0] frac_t, frac_h, turn;
        longint unsigned hprod;
        t = longint'(signed'(tv));
        off = longint'(signed'(cur_offset));
        amp = longint'(signed'(cur_amp));
        ph = longint'(signed'(cur_phase));
        per = (cur_period == 0) ? 1 : longint'(cur_period);
        rem = t % per;
        if (rem < 0) rem += per;
        frac_t = 32'((longint'(rem) << 32) / per);
        hprod = longint'(ph) * longint'(INV_TWO_PI_Q32);
        frac_h = 32'(hprod >> FRACB);
        turn = frac_t + frac_h;
        term = 0;
        res = '0;
        case (cur_mode)
            MODE_CONST:  term = amp;
            MODE_LINEAR: term = scale_round(amp, t + ph, FRACB);
            MODE_SINE: begin
                sin_cos_q30(turn, s, c);
                term = scale_round(amp, s, 30);
            end
            MODE_COSINE: begin
                sin_cos_q30(turn, s, c);
                term = scale_round(amp, c, 30);
            end
            MODE_PULSE: begin
                sin_cos_q30(turn, s, c);
                term = (amp < 0) ? -amp : amp;
                if (s < 0) term = -term;
            end
            MODE_TRIANGLE: begin
                g = longint'(signed'(turn));
                if (g > 64'sd1073741824) tri_q30 = 64'sd2147483648 - g;
                else if (g < -64'sd1073741824) tri_q30 = -64'sd2147483648 - g;
                else tri_q30 = g;
                term = scale_round(amp, tri_q30, 30);
            end
            MODE_SAW: begin
                rem = (t + ph) % per;
                term = scale_round(amp, 2 * rem - per, FRACB + 1);
            end
            default: return res;
        endcase
        sum = off + term;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647; res.sat = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648; res.sat = 1'b1;
        end
        res.value = 32'(sum);
        return res;
    endfunction

    // result checker
    always @(posedge clk) begin : result_check
        wave_sample_t exp_s;
        if (rst_n && done) begin
            if (pending_samples.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h sat %b", wave_value, saturated);
            end else begin
                exp_s = pending_samples.pop_front();
                n_checked++;
                if (wave_value !== exp_s.value || saturated !== exp_s.sat) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %h sat %b, got %h sat %b",
                                 exp_s.value, exp_s.sat, wave_value, saturated);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk) begin
        if ((start && !busy) || done || (psel && penable)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIM) begin
            $display("watchdog expired after %0d idle cycles", idle_cnt);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_time(input logic [31:0] tv);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        time_value = tv;
        do @(posedge clk); while (busy);
        pending_samples.push_back(eval_wave(tv));
        n_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_samples.size() != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        wait_idle();
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_MODE:   cur_mode = pwe_mode_t'(val[2:0]);
            REG_OFFSET: cur_offset = val;
            REG_AMP:    cur_amp = val;
            REG_PERIOD: cur_period = val[30:0];
            REG_PHASE:  cur_phase = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic set_all(input pwe_mode_t m, input logic [31:0] off, input logic [31:0] amp,
                           input logic [31:0] per, input logic [31:0] ph);
        cfg_write(REG_MODE, 32'(m));
        cfg_write(REG_OFFSET, off);
        cfg_write(REG_AMP, amp);
        cfg_write(REG_PERIOD, per);
        cfg_write(REG_PHASE, ph);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(0, 262144)) - 131072);
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'd1;
            3: return $urandom_range(1, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_time(32'd0);
        send_time(32'h7FFF_FFFF);
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 8; m++) begin
            set_all(pwe_mode_t'(m), 32'h0000_8000, 32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000);
            send_time(32'h8000_0000);
            send_time(32'h0001_4000);
        end
    endtask

    task automatic test_extremes();
        // clipping in both directions, zero period acting as one lsb
        set_all(MODE_CONST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 32'd0);
        send_time(32'd5);
        set_all(MODE_LINEAR, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000);
        send_time(32'h8000_0000);
        send_time(32'h7FFF_FFFF);
        set_all(MODE_SAW, 32'd0, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
        send_time(32'hFFFF_FFFF);
        cfg_write(REG_PERIOD, 32'h7FFF_FFFF);
        send_time(32'h8000_0000);
        set_all(MODE_TRIANGLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
        send_time(32'h1234_5678);
    endtask

    task automatic test_random();
        int burst;
        for (int ph = 0; ph < 12; ph++) begin
            set_all(pwe_mode_t'($urandom_range(0, 7)), pick_word(), pick_word(),
                    pick_period(), pick_word());
            burst = $urandom_range(60, 100);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 2) == 0) send_time(pick_word());
                else send_time($urandom());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < STAGES; i++) atan_q32_tab[i] = atan_entry(i);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_each_mode();
        test_extremes();
        test_random();
        wait_idle();
        repeat (DRAIN_CYC) @(posedge clk);
        $display("sent %0d time samples across all modes, %0d register writes",
                 n_sent, n_cfg);
        $display("checked %0d results, %0d mismatches, %0d left pending",
                 n_checked, n_mismatch, pending_samples.size());
        if (n_mismatch == 0 && pending_samples.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- periodic_waveform_evaluator_unit.f -----
sv/pwe_pkg.sv
sv/pwe_divpipe.sv
sv/pwe_cordic.sv
sv/periodic_waveform_evaluator_unit.sv
verif/tb_top.sv
